>>> rtl/skvc_pkg.sv
// Package for the session key/value cache: request and status codes,
// sequencer state type, default sizes and the byte mask helper.
// No dependencies.
package skvc_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int DEF_ENTRIES        = 16;
    localparam int DEF_MAX_KEY_BYTES  = 32;
    localparam int DEF_MAX_DATA_BYTES = 512;

    // Request kinds
    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_FETCH  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Word counter saturation value
    localparam logic [7:0] WC_MAX = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ZERO,
        S_KCOPY,
        S_SCAN,
        S_KRD,
        S_KCMP,
        S_DRD,
        S_DSTR
    } t_state;

    // Keep the bytes of word widx that lie inside a block of len bytes
    function automatic logic [63:0] f_byte_mask(input logic [12:0] len,
                                                input logic [9:0]  widx);
        logic [13:0] start_b;
        logic [13:0] rem;
        logic [63:0] m;
        start_b = {1'b0, widx, 3'b000};
        rem     = '0;
        if ({1'b0, len} <= start_b) begin
            m = '0;
        end else begin
            rem = {1'b0, len} - start_b;
            if (rem >= 14'd8) begin
                m = '1;
            end else begin
                m = ~(64'hFFFF_FFFF_FFFF_FFFF << {rem[2:0], 3'b000});
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/skvc_ram.sv
// Generic single-port RAM with registered read for the cache stores.
// No dependencies.
module skvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Up to one write plus one registered read per cycle, both at i_addr
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/session_key_value_cache.sv
// Top level of the session key/value cache: request intake, sequencer,
// key and data RAMs. Depends on skvc_pkg and skvc_ram.
//
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// request  | start, busy (in when !busy)| i_operation i_key_length i_data_length
//          |                            | i_request_word i_last_word
// result   | o_result_valid             | o_status o_result_length o_result_word
//          |                            | o_result_last
//
// A request beat without last word is taken while idle and keeps busy low.
// After the last beat the sequencer runs: store zero-fills the data words not
// sent, copies the KW key words of the slot (S_KCOPY) and then gives its result;
// fetch/delete skip a slot with a length mismatch in S_SCAN, else read and
// compare its key words one at a time (S_KRD, S_KCMP; one shared 64-bit comparator
// on the key RAM port); a fetch hit streams one result beat per cycle.
// Reset (i_rst_n low, synchronous) clears lengths, slot pointer and counters.
// The receiver cannot stall; results go out as they are produced.
module session_key_value_cache
    import skvc_pkg::*;
#(
    parameter int ENTRIES        = DEF_ENTRIES,
    parameter int MAX_KEY_BYTES  = DEF_MAX_KEY_BYTES,
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_key_length,
    input  logic [9:0]  i_data_length,
    input  logic [63:0] i_request_word,
    input  logic        i_last_word,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [9:0]  o_result_length,
    output logic [63:0] o_result_word,
    output logic        o_result_last
);

    localparam int KW   = (MAX_KEY_BYTES + 7) / 8;
    localparam int DW   = (MAX_DATA_BYTES + 7) / 8;
    localparam int SB   = $clog2(ENTRIES);
    localparam int KWB  = (KW > 1) ? $clog2(KW) : 1;
    localparam int KWP  = 2 ** KWB;
    localparam int DWB  = $clog2(DW);
    localparam int DWP  = 2 ** DWB;
    localparam int KAB  = $clog2(ENTRIES * KWP);
    localparam int DAB  = $clog2(ENTRIES * DWP);

    // Sequencer and request state
    t_state       r_state, n_state;
    logic [7:0]   r_wc;
    logic [1:0]   r_op;
    logic [5:0]   r_klen;
    logic [9:0]   r_dlen;
    logic [63:0]  r_req_key [KWP];
    logic [5:0]   r_key_sizes [ENTRIES];
    logic [9:0]   r_data_sizes [ENTRIES];
    logic [SB-1:0] r_wslot, n_wslot;
    logic [SB-1:0] r_slot, n_slot;
    logic [7:0]   r_w, n_w;
    logic         r_zfill;
    logic [9:0]   r_fdlen, n_fdlen;

    // Output registers
    logic         r_ovalid, n_ovalid;
    logic [1:0]   r_status, n_status;
    logic [9:0]   r_olen, n_olen;
    logic [63:0]  r_oword, n_oword;
    logic         r_olast, n_olast;

    // RAM ports
    logic            key_we, data_we;
    logic [KAB-1:0]  key_addr;
    logic [DAB-1:0]  data_addr;
    logic [63:0]     key_wdata, data_wdata, key_rdata, data_rdata;

    // Length table update
    logic            sz_we;
    logic [SB-1:0]   sz_idx;
    logic [5:0]      sz_k;
    logic [9:0]      sz_d;

    // Beat intake: fields of the current request
    logic        acc;
    logic [1:0]  c_op;
    logic [5:0]  c_klen;
    logic [9:0]  c_dlen;
    logic        c_valid;
    logic [7:0]  c_kw, c_dw;
    logic [7:0]  wc_inc, rec, widx;
    logic        c_kwr, c_dwr;
    logic [63:0] c_kword, c_dword;

    assign acc    = start && !busy;
    assign c_op   = (r_wc == 8'd0) ? i_operation   : r_op;
    assign c_klen = (r_wc == 8'd0) ? i_key_length  : r_klen;
    assign c_dlen = (r_wc == 8'd0) ? i_data_length : r_dlen;
    assign c_valid = (c_klen <= MAX_KEY_BYTES)
                   && (c_op != OP_STORE || c_dlen <= MAX_DATA_BYTES);
    assign c_kw   = c_valid ? 8'(({2'b00, c_klen} + 8'd7) >> 3) : 8'd0;
    assign c_dw   = (c_valid && c_op == OP_STORE) ?
                    8'(({1'b0, c_dlen} + 11'd7) >> 3) : 8'd0;
    assign wc_inc = (r_wc == WC_MAX) ? WC_MAX : r_wc + 8'd1;
    assign rec    = (wc_inc > c_kw) ? wc_inc - c_kw : 8'd0;
    assign widx   = r_wc - c_kw;
    assign c_kwr  = acc && c_valid && (r_wc < c_kw);
    assign c_dwr  = acc && c_valid && c_op == OP_STORE && (r_wc >= c_kw)
                  && ({1'b0, r_wc} < {1'b0, c_kw} + {1'b0, c_dw});
    assign c_kword = i_request_word
                   & f_byte_mask({7'd0, c_klen}, {2'b00, r_wc});
    assign c_dword = i_request_word
                   & f_byte_mask({3'd0, c_dlen}, {2'b00, widx});

    // Latched request, derived counts for the sequencer
    logic        e_valid;
    logic [7:0]  e_kw, e_dw, f_dw;

    assign e_valid = (r_klen <= MAX_KEY_BYTES)
                   && (r_op != OP_STORE || r_dlen <= MAX_DATA_BYTES);
    assign e_kw = 8'(({2'b00, r_klen} + 8'd7) >> 3);
    assign e_dw = 8'(({1'b0, r_dlen} + 11'd7) >> 3);
    assign f_dw = 8'(({1'b0, r_fdlen} + 11'd7) >> 3);

    // Shared key comparator
    logic key_eq;
    assign key_eq = (key_rdata == r_req_key[KWB'(r_w)]);

    // Sequencer: next state, RAM control, results
    always_comb begin
        logic do_hit;
        logic do_next;
        n_state    = r_state;
        n_w        = r_w;
        n_slot     = r_slot;
        n_wslot    = r_wslot;
        n_fdlen    = r_fdlen;
        n_ovalid   = 1'b0;
        n_status   = ST_OK;
        n_olen     = '0;
        n_oword    = '0;
        n_olast    = 1'b0;
        key_we     = 1'b0;
        key_addr   = {r_slot, KWB'(r_w)};
        key_wdata  = r_req_key[KWB'(r_w)];
        data_we    = 1'b0;
        data_addr  = {r_slot, DWB'(r_w)};
        data_wdata = '0;
        sz_we      = 1'b0;
        sz_idx     = r_slot;
        sz_k       = '0;
        sz_d       = '0;
        do_hit     = 1'b0;
        do_next    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                data_we    = c_dwr;
                data_addr  = {r_wslot, DWB'(widx)};
                data_wdata = c_dword;
                if (acc && i_last_word) begin
                    n_state = S_EXEC;
                    n_w     = rec;
                end
            end
            S_EXEC: begin
                if (r_op == OP_STORE) begin
                    if (!e_valid) begin
                        n_ovalid = 1'b1;
                        n_status = ST_REJECT;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_zfill) begin
                        n_state = S_ZERO;
                    end else begin
                        n_w     = '0;
                        n_state = S_KCOPY;
                    end
                end else if (r_op != OP_FETCH && r_op != OP_DELETE || !e_valid) begin
                    n_ovalid = 1'b1;
                    n_status = ST_MISS;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_slot  = '0;
                    n_state = S_SCAN;
                end
            end
            S_ZERO: begin
                data_we   = 1'b1;
                data_addr = {r_wslot, DWB'(r_w)};
                if (r_w == e_dw - 8'd1) begin
                    n_w     = '0;
                    n_state = S_KCOPY;
                end else begin
                    n_w = r_w + 8'd1;
                end
            end
            S_KCOPY: begin
                key_we   = 1'b1;
                key_addr = {r_wslot, KWB'(r_w)};
                if (r_w == 8'(KW - 1)) begin
                    sz_we    = 1'b1;
                    sz_idx   = r_wslot;
                    sz_k     = r_klen;
                    sz_d     = r_dlen;
                    n_wslot  = (r_wslot == SB'(ENTRIES - 1)) ? '0 : r_wslot + 1'b1;
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_w = r_w + 8'd1;
                end
            end
            S_SCAN: begin
                if (r_key_sizes[r_slot] == r_klen) begin
                    if (e_kw == 8'd0) begin
                        do_hit = 1'b1;
                    end else begin
                        n_w     = '0;
                        n_state = S_KRD;
                    end
                end else begin
                    do_next = 1'b1;
                end
            end
            S_KRD: begin
                n_state = S_KCMP;
            end
            S_KCMP: begin
                if (!key_eq) begin
                    do_next = 1'b1;
                end else if (r_w == e_kw - 8'd1) begin
                    do_hit = 1'b1;
                end else begin
                    n_w     = r_w + 8'd1;
                    n_state = S_KRD;
                end
            end
            S_DRD: begin
                n_state = S_DSTR;
            end
            S_DSTR: begin
                data_addr = {r_slot, DWB'(r_w + 8'd1)};
                n_ovalid  = 1'b1;
                n_status  = ST_OK;
                n_olen    = r_fdlen;
                n_oword   = data_rdata
                          & f_byte_mask({3'd0, r_fdlen}, {2'b00, r_w});
                if (r_w == f_dw - 8'd1) begin
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + 8'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Slot mismatch: try the next slot or report a miss
        if (do_next) begin
            if (r_slot == SB'(ENTRIES - 1)) begin
                n_ovalid = 1'b1;
                n_status = ST_MISS;
                n_olast  = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_slot  = r_slot + 1'b1;
                n_state = S_SCAN;
            end
        end

        // Key match: delete clears lengths, fetch starts the data stream or, with no data, gives one OK beat
        if (do_hit) begin
            if (r_op == OP_DELETE) begin
                sz_we    = 1'b1;
                n_ovalid = 1'b1;
                n_status = ST_OK;
                n_olast  = 1'b1;
                n_state  = S_IDLE;
            end else if (r_data_sizes[r_slot] == 10'd0) begin
                n_ovalid = 1'b1;
                n_status = ST_OK;
                n_olast  = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_fdlen = r_data_sizes[r_slot];
                n_w     = '0;
                n_state = S_DRD;
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wc     <= '0;
            r_op     <= '0;
            r_klen   <= '0;
            r_dlen   <= '0;
            r_wslot  <= '0;
            r_slot   <= '0;
            r_w      <= '0;
            r_zfill  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_key_sizes[i]  <= '0;
                r_data_sizes[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_wslot  <= n_wslot;
            r_slot   <= n_slot;
            r_w      <= n_w;
            r_ovalid <= n_ovalid;
            if (acc) begin
                r_wc <= i_last_word ? 8'd0 : wc_inc;
                if (r_wc == 8'd0) begin
                    r_op   <= i_operation;
                    r_klen <= i_key_length;
                    r_dlen <= i_data_length;
                end
                if (i_last_word) begin
                    r_zfill <= (rec < c_dw);
                end
            end
            if (sz_we) begin
                r_key_sizes[sz_idx]  <= sz_k;
                r_data_sizes[sz_idx] <= sz_d;
            end
        end
    end

    // Request key words and result payload
    always_ff @(posedge i_clk) begin
        if (acc && r_wc == 8'd0) begin
            for (int i = 0; i < KWP; i++) begin
                r_req_key[i] <= '0;
            end
        end
        if (c_kwr) begin
            r_req_key[KWB'(r_wc)] <= c_kword;
        end
        r_fdlen  <= n_fdlen;
        r_status <= n_status;
        r_olen   <= n_olen;
        r_oword  <= n_oword;
        r_olast  <= n_olast;
    end

    // Key store: KWP words per slot
    skvc_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES * KWP)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_addr  (key_addr),
        .i_wdata (key_wdata),
        .o_rdata (key_rdata)
    );

    // Data store: DWP words per slot
    skvc_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES * DWP)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_addr  (data_addr),
        .i_wdata (data_wdata),
        .o_rdata (data_rdata)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_ovalid;
    assign o_status        = r_status;
    assign o_result_length = r_olen;
    assign o_result_word   = r_oword;
    assign o_result_last   = r_olast;

`ifndef ASSERT_OFF
    // Slot pointer stays inside the table
    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= SB'(ENTRIES - 1))
        else $error("write slot out of range");

    // A fetch stream never breaks before its last beat
    a_stream_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result_last |=> o_result_valid)
        else $error("result stream gap");

    // Result valid drops after the last beat of a request
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result_last |=> !o_result_valid)
        else $error("result right after last beat");

    // Only fetch hits carry a length and several beats
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status != ST_OK |-> o_result_last && o_result_length == 10'd0)
        else $error("miss or reject not a single beat");
`endif

endmodule

>>> sim/skvc_checker.sv
// Checker for the session key/value cache: watches request and result beats,
// predicts every result beat and compares it field by field.
// Depends on skvc_pkg.
module skvc_checker
    import skvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_key_length,
    input  logic [9:0]  i_data_length,
    input  logic [63:0] i_request_word,
    input  logic        i_last_word,
    input  logic        i_result_valid,
    input  logic [1:0]  i_status,
    input  logic [9:0]  i_result_length,
    input  logic [63:0] i_result_word,
    input  logic        i_result_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    localparam int SLOTS     = DEF_ENTRIES;
    localparam int KEY_MAX   = DEF_MAX_KEY_BYTES;
    localparam int DATA_MAX  = DEF_MAX_DATA_BYTES;
    localparam int KEY_WRDS  = (KEY_MAX + 7) / 8;
    localparam int DATA_WRDS = (DATA_MAX + 7) / 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  length;
        logic [63:0] word;
        logic        last;
    } t_answer;

    // Shadow copy of the cache contents
    logic [63:0] key_mem  [SLOTS][KEY_WRDS];
    logic [63:0] data_mem [SLOTS][DATA_WRDS];
    int          key_len  [SLOTS];
    int          data_len [SLOTS];
    int          wslot;
    int          wcount;
    logic [1:0]  cur_op;
    int          cur_klen;
    int          cur_dlen;
    logic [63:0] cur_key  [KEY_WRDS];
    t_answer     answers_due[$];

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            key_len[s]  = 0;
            data_len[s] = 0;
            for (int w = 0; w < KEY_WRDS; w++) key_mem[s][w] = '0;
            for (int w = 0; w < DATA_WRDS; w++) data_mem[s][w] = '0;
        end
        for (int w = 0; w < KEY_WRDS; w++) cur_key[w] = '0;
        wslot     = 0;
        wcount    = 0;
        cur_op    = OP_STORE;
        cur_klen  = 0;
        cur_dlen  = 0;
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    // Keep the bytes of word w that fall inside a block of len bytes
    function automatic logic [63:0] keep_bytes(int len, int w);
        int rem;
        rem = len - 8 * w;
        if (rem <= 0) return '0;
        if (rem >= 8) return '1;
        return (64'h1 << (8 * rem)) - 64'h1;
    endfunction

    function automatic void push_answer(logic [1:0] st, int len, logic [63:0] wd,
                                        logic lst);
        t_answer a;
        a.status = st;
        a.length = len[9:0];
        a.word   = wd;
        a.last   = lst;
        answers_due.push_back(a);
    endfunction

    // Advance the shadow cache by one request beat
    task automatic predict_beat(logic [1:0] op, logic [5:0] kl, logic [9:0] dl,
                                logic [63:0] wd, logic lst);
        logic valid;
        int   kw, dw, idx, got, hit, nw;
        logic eq;
        if (wcount == 0) begin
            cur_op   = op;
            cur_klen = kl;
            cur_dlen = dl;
            for (int w = 0; w < KEY_WRDS; w++) cur_key[w] = '0;
        end
        valid = (cur_klen <= KEY_MAX) && (cur_op != OP_STORE || cur_dlen <= DATA_MAX);
        kw = valid ? (cur_klen + 7) / 8 : 0;
        dw = (valid && cur_op == OP_STORE) ? (cur_dlen + 7) / 8 : 0;
        idx = wcount;
        if (valid && idx < kw)
            cur_key[idx] = wd & keep_bytes(cur_klen, idx);
        else if (valid && idx < kw + dw)
            data_mem[wslot][idx - kw] = wd & keep_bytes(cur_dlen, idx - kw);
        if (wcount < 255) wcount++;
        if (!lst) return;
        got    = (wcount > kw) ? wcount - kw : 0;
        wcount = 0;
        if (cur_op == OP_STORE) begin
            if (!valid) begin
                push_answer(ST_REJECT, 0, '0, 1'b1);
                return;
            end
            for (int w = got; w < dw; w++) data_mem[wslot][w] = '0;
            for (int w = 0; w < KEY_WRDS; w++) key_mem[wslot][w] = cur_key[w];
            key_len[wslot]  = cur_klen;
            data_len[wslot] = cur_dlen;
            wslot = (wslot + 1) % SLOTS;
            push_answer(ST_OK, 0, '0, 1'b1);
            return;
        end
        if (cur_op != OP_FETCH && cur_op != OP_DELETE || !valid) begin
            push_answer(ST_MISS, 0, '0, 1'b1);
            return;
        end
        // first slot with an equal key, lowest index wins
        hit = SLOTS;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            eq = (key_len[s] == cur_klen);
            for (int w = 0; w < kw; w++)
                if (key_mem[s][w] != cur_key[w]) eq = 1'b0;
            if (eq) hit = s;
        end
        if (hit == SLOTS) begin
            push_answer(ST_MISS, 0, '0, 1'b1);
        end else if (cur_op == OP_DELETE) begin
            key_len[hit]  = 0;
            data_len[hit] = 0;
            push_answer(ST_OK, 0, '0, 1'b1);
        end else begin
            nw = (data_len[hit] + 7) / 8;
            if (nw == 0) push_answer(ST_OK, 0, '0, 1'b1);
            for (int w = 0; w < nw; w++)
                push_answer(ST_OK, data_len[hit],
                            data_mem[hit][w] & keep_bytes(data_len[hit], w),
                            w == nw - 1);
        end
    endtask

    // Sample both channels on the clock edge that accepts their beats
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                predict_beat(i_operation, i_key_length, i_data_length,
                             i_request_word, i_last_word);
            if (i_result_valid) begin
                o_results++;
                if (answers_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("ERROR: unexpected result beat st=%0d len=%0d word=%h",
                                 i_status, i_result_length, i_result_word);
                end else begin
                    want = answers_due.pop_front();
                    if (want.status != i_status || want.length != i_result_length ||
                        want.word != i_result_word || want.last != i_result_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"ERROR: result mismatch exp st=%0d len=%0d ",
                                      "word=%h last=%0d, got st=%0d len=%0d ",
                                      "word=%h last=%0d"},
                                     want.status, want.length, want.word, want.last,
                                     i_status, i_result_length, i_result_word,
                                     i_result_last);
                    end
                end
            end
            o_pending = answers_due.size();
        end
    end

endmodule

>>> sim/tb.sv
// Testbench top for the session key/value cache: clock, reset, request
// stimulus and verdict. Depends on skvc_pkg, skvc_checker and the RTL top.
module tb;
    import skvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL        = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [5:0]  i_key_length;
    logic [9:0]  i_data_length;
    logic [63:0] i_request_word;
    logic        i_last_word;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [9:0]  o_result_length;
    logic [63:0] o_result_word;
    logic        o_result_last;
    int          errors;
    int          pending;
    int          results;
    int          cycles;
    int          requests;

    // Known keys so that fetches and deletes actually hit
    logic [63:0] pool_key [POOL][4];
    int          pool_len [POOL] = '{0, 1, 7, 8, 9, 16, 31, 32};
    logic [63:0] req_key  [4];

    session_key_value_cache dut (.*);

    skvc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_operation(i_operation), .i_key_length(i_key_length),
        .i_data_length(i_data_length), .i_request_word(i_request_word),
        .i_last_word(i_last_word), .i_result_valid(o_result_valid),
        .i_status(o_status), .i_result_length(o_result_length),
        .i_result_word(o_result_word), .i_result_last(o_result_last),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // One request beat: random gap, then hold until accepted
    task automatic send_beat(logic [1:0] op, logic [5:0] kl, logic [9:0] dl,
                             logic [63:0] wd, logic lst);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_key_length   <= kl;
        i_data_length  <= dl;
        i_request_word <= wd;
        i_last_word    <= lst;
        do @(posedge i_clk); while (busy);
    endtask

    // Whole request: key words from req_key, then data words; nwords beats
    task automatic send_request(logic [1:0] op, int kl, int dl, int nwords);
        int kw;
        logic [63:0] wd;
        kw = (kl + 7) / 8;
        if (nwords < 1) nwords = 1;
        for (int i = 0; i < nwords; i++) begin
            wd = (i < kw && i < 4) ? req_key[i] : rnd64();
            if (i == 0)
                send_beat(op, kl[5:0], dl[9:0], wd, nwords == 1);
            else
                send_beat(2'($urandom), 6'($urandom), 10'($urandom), wd,
                          i == nwords - 1);
        end
        requests++;
    endtask

    function automatic int exact_words(logic [1:0] op, int kl, int dl);
        if (op == OP_STORE) return (kl + 7) / 8 + (dl + 7) / 8;
        return (kl + 7) / 8;
    endfunction

    // Pick a known key, leaving junk above its length
    task automatic pick_key(int p);
        for (int w = 0; w < 4; w++) req_key[w] = pool_key[p][w];
    endtask

    // Let the checker book the last beat, then drain
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] op;
        int p, kl, dl, nw, r;
        cycles         = 0;
        requests       = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_STORE;
        i_key_length   = '0;
        i_data_length  = '0;
        i_request_word = '0;
        i_last_word    = 1'b0;
        for (int k = 0; k < POOL; k++)
            for (int w = 0; w < 4; w++) pool_key[k][w] = rnd64();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, zero-length key fetch on empty slots
        send_request(OP_FETCH, 0, 0, 1);
        send_request(OP_STORE, 0, 0, 1);
        send_request(OP_FETCH, 0, 0, 1);
        // full-size key and data, fetched back
        pick_key(7);
        send_request(OP_STORE, 32, 512, exact_words(OP_STORE, 32, 512));
        send_request(OP_FETCH, 32, 1023, 4);
        // too long key or data
        send_request(OP_STORE, 33, 8, 6);
        send_request(OP_STORE, 8, 513, 3);
        send_request(OP_STORE, 63, 1023, 2);
        send_request(OP_FETCH, 63, 0, 8);
        send_request(OP_DELETE, 40, 0, 5);
        // unknown operation
        send_request(2'd3, 8, 16, 3);
        // short and long streams
        pick_key(4);
        send_request(OP_STORE, 9, 100, 3);
        send_request(OP_FETCH, 9, 0, 2);
        pick_key(2);
        send_request(OP_STORE, 7, 13, 6);
        send_request(OP_FETCH, 7, 0, 4);
        // word counter saturation on a long fetch
        pick_key(7);
        send_request(OP_FETCH, 32, 0, 300);
        // delete, then fetch misses
        send_request(OP_DELETE, 32, 0, 4);
        send_request(OP_FETCH, 32, 0, 4);
        send_request(OP_DELETE, 0, 0, 1);
        drain();

        // Random requests, mostly over known keys
        for (int n = 0; n < 200; n++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_STORE : (r < 80) ? OP_FETCH : (r < 95) ? OP_DELETE : 2'd3;
            if ($urandom_range(0, 9) == 0) begin
                kl = $urandom_range(0, 63);
                for (int w = 0; w < 4; w++) req_key[w] = rnd64();
            end else begin
                p = $urandom_range(0, POOL - 1);
                kl = pool_len[p];
                pick_key(p);
            end
            r = $urandom_range(0, 99);
            dl = (r < 80) ? $urandom_range(0, 64) :
                 (r < 95) ? $urandom_range(65, 512) : $urandom_range(513, 1023);
            nw = exact_words(op, kl, dl);
            r = $urandom_range(0, 99);
            if (r < 8 && nw > 1) nw = $urandom_range(1, nw - 1);
            else if (r < 15) nw = nw + $urandom_range(1, 3);
            send_request(op, kl, dl, nw);
            if (n == 100) drain();
        end

        drain();
        $display("Ran %0d requests, checked %0d result beats, %0d mismatches.",
                 requests, results, errors);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
